// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define GCD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");
`else
`define GCD_ASSERT(lbl, prop)
`define GCD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/core/gcd_pkg.sv =====
package gcd_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 16;

  localparam int unsigned LON_W   = 25;
  localparam int unsigned LAT_W   = 24;
  localparam int unsigned RAD_W   = 23;
  localparam int unsigned CHORD_W = 24;
  localparam int unsigned IN_W    = 2 * (LON_W + LAT_W);
  localparam int unsigned IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_TW  = ((CHORD_W + 7) / 8) * 8;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(6378137);

  localparam longint ANG_PERIOD = 360 * (64'd1 << ANGLE_FRAC_BITS);
  localparam longint ANG_HALF   = 180 * (64'd1 << ANGLE_FRAC_BITS);
  localparam longint ANG_QUART  = 90 * (64'd1 << ANGLE_FRAC_BITS);
  localparam int unsigned MAG_W = $clog2(ANG_HALF + 1);
  localparam int unsigned RED_W = MAG_W + 2;

  localparam int unsigned DEG_W = 27;
  localparam logic [DEG_W-1:0] DEG_TO_RAD_Q32 = DEG_W'(74961321);
  localparam int unsigned ZP_W  = MAG_W + DEG_W;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CW = 33;
  typedef logic signed [CW-1:0] cval_t;
  localparam cval_t CORDIC_GAIN_Q30 = CW'(652032874);

  localparam int unsigned SUM_W       = 64;
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned SQRT_STEPS  = 32;
  localparam int unsigned LAT_CORDIC  = CORDIC_STEPS + 3;
  localparam int unsigned LAT_TOTAL   = LAT_CORDIC + 4 + SQRT_STEPS + 2;

  function automatic cval_t atan_q30(input int unsigned i);
    cval_t a;
    unique case (i)
      0:  a = CW'(843314856);
      1:  a = CW'(497837829);
      2:  a = CW'(263043836);
      3:  a = CW'(133525158);
      4:  a = CW'(67021686);
      5:  a = CW'(33543515);
      6:  a = CW'(16775850);
      7:  a = CW'(8388437);
      8:  a = CW'(4194282);
      9:  a = CW'(2097149);
      10: a = CW'(1048575);
      11: a = CW'(524287);
      12: a = CW'(262143);
      13: a = CW'(131071);
      14: a = CW'(65535);
      15: a = CW'(32767);
      16: a = CW'(16383);
      17: a = CW'(8191);
      18: a = CW'(4095);
      19: a = CW'(2047);
      20: a = CW'(1023);
      21: a = CW'(511);
      22: a = CW'(255);
      23: a = CW'(127);
      24: a = CW'(63);
      25: a = CW'(31);
      26: a = CW'(15);
      27: a = CW'(8);
      28: a = CW'(4);
      29: a = CW'(2);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/gcd_sincos.sv =====
module gcd_sincos (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [gcd_pkg::LON_W-1:0]  angle_i,
  output gcd_pkg::cval_t                    sin_o,
  output gcd_pkg::cval_t                    cos_o
);

  localparam int unsigned RW = gcd_pkg::RED_W;
  localparam int unsigned NS = gcd_pkg::CORDIC_STEPS;
  localparam int unsigned F  = gcd_pkg::ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] PERIOD_S = RW'(gcd_pkg::ANG_PERIOD);
  localparam logic signed [RW-1:0] HALF_S   = RW'(gcd_pkg::ANG_HALF);
  localparam logic signed [RW-1:0] QUART_S  = RW'(gcd_pkg::ANG_QUART);
  localparam logic [gcd_pkg::ZP_W-1:0] Z_RND = gcd_pkg::ZP_W'(64'd1 << (F + 1));

  logic signed [RW-1:0] r0, r1, r2;
  logic sneg_d, cneg_d;
  logic [gcd_pkg::MAG_W-1:0] m_d, m_q;
  logic sneg1_q, cneg1_q;
  logic [gcd_pkg::ZP_W-1:0] zp;

  gcd_pkg::cval_t x_q [NS+1];
  gcd_pkg::cval_t y_q [NS+1];
  gcd_pkg::cval_t z_q [NS+1];
  logic sneg_q [NS+1];
  logic cneg_q [NS+1];
  gcd_pkg::cval_t sin_q, cos_q;

  // fold the angle into the first quadrant, keep the signs
  always_comb begin
    r0 = RW'(angle_i);
    if (r0 < 0) begin
      r0 = r0 + PERIOD_S;
    end
    if (r0 > HALF_S) begin
      r0 = r0 - PERIOD_S;
    end
    sneg_d = (r0 < 0);
    r1     = sneg_d ? -r0 : r0;
    cneg_d = (r1 > QUART_S);
    r2     = cneg_d ? (HALF_S - r1) : r1;
    m_d    = r2[gcd_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q     <= m_d;
      sneg1_q <= sneg_d;
      cneg1_q <= cneg_d;
    end
  end

  assign zp = (gcd_pkg::ZP_W'(m_q) * gcd_pkg::ZP_W'(gcd_pkg::DEG_TO_RAD_Q32)) + Z_RND;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= gcd_pkg::CORDIC_GAIN_Q30;
      y_q[0]    <= '0;
      z_q[0]    <= gcd_pkg::CW'(zp >> (F + 2));
      sneg_q[0] <= sneg1_q;
      cneg_q[0] <= cneg1_q;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    gcd_pkg::cval_t xs, ys, atn;
    assign xs  = x_q[i] >>> i;
    assign ys  = y_q[i] >>> i;
    assign atn = gcd_pkg::atan_q30(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - atn;
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + atn;
        end
        sneg_q[i+1] <= sneg_q[i];
        cneg_q[i+1] <= cneg_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sneg_q[NS] ? -y_q[NS] : y_q[NS];
      cos_q <= cneg_q[NS] ? -x_q[NS] : x_q[NS];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== rtl/core/gcd_isqrt.sv =====
module gcd_isqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [gcd_pkg::SUM_W-1:0]    v_i,
  output logic [gcd_pkg::ROOT_W-1:0]   root_o
);

  localparam int unsigned N = gcd_pkg::SQRT_STEPS;
  localparam int unsigned W = gcd_pkg::SUM_W;

  logic [W-1:0] rem_q  [N+1];
  logic [W-1:0] root_q [N+1];

  assign rem_q[0]  = v_i;
  assign root_q[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] BIT = W'(64'd1 << (W - 2 - 2 * k));
    logic [W-1:0] trial;
    assign trial = root_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[k] >= trial) begin
          rem_q[k+1]  <= rem_q[k] - trial;
          root_q[k+1] <= (root_q[k] >> 1) + BIT;
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= root_q[k] >> 1;
        end
      end
    end
  end

  assign root_o = root_q[N][gcd_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/core/globe_chord_distance_core.sv =====
// Chord length between two points on a sphere. Each item (two longitude and
// latitude pairs, degrees with 16 fraction bits) yields one 24-bit distance in
// whole metres, rounded to nearest and saturated. The pipeline takes one
// transfer per cycle. Its stages are 33 of range folding and CORDIC
// sine/cosine, 4 of products, differences and squares, 32 of square root,
// 2 of radius scaling. Back-pressure on the output stalls the whole
// pipeline. The radius register is used at the end of the pipeline, so
// write it only while no item is in flight.
`include "assert_macros.svh"

module globe_chord_distance_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // lon_a[24:0], lat_a[48:25], lon_b[73:49], lat_b[97:74], zero pad
  input  logic [gcd_pkg::IN_TW-1:0]     s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // chord_m[23:0]
  output logic [gcd_pkg::OUT_TW-1:0]    m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic [gcd_pkg::RAD_W-1:0]     cfg_data_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o
);

  localparam int unsigned LW = gcd_pkg::LON_W;
  localparam int unsigned AW = gcd_pkg::LAT_W;
  localparam int unsigned CW = gcd_pkg::CW;
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned DW = CW + 2;
  localparam int unsigned SW = gcd_pkg::SUM_W;
  localparam int unsigned MW = gcd_pkg::ROOT_W + gcd_pkg::RAD_W;
  localparam int unsigned LT = gcd_pkg::LAT_TOTAL;
  localparam logic signed [PW-1:0] P_RND = PW'(64'd1 << 29);
  localparam logic [MW-1:0] M_RND = MW'(64'd1 << 29);
  localparam logic [MW-31:0] CHORD_MAX = (MW-30)'({gcd_pkg::CHORD_W{1'b1}});

  logic [gcd_pkg::RAD_W-1:0] rad_q;
  logic [LT-1:0] vld_q;
  logic pipe_en, s_accept;

  logic signed [LW-1:0] lon_a, lat_a, lon_b, lat_b;
  gcd_pkg::cval_t slon_a, clon_a, slat_a, clat_a;
  gcd_pkg::cval_t slon_b, clon_b, slat_b, clat_b;

  logic signed [PW-1:0] pxa_q, pza_q, pxb_q, pzb_q;
  gcd_pkg::cval_t slat_a_q, slat_b_q;
  logic signed [PW-1:0] rxa, rza, rxb, rzb;
  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  logic [DW-1:0] ax, ay, az;
  logic [SW-1:0] sx_q, sy_q, sz_q, sum_q;
  logic [gcd_pkg::ROOT_W-1:0] root;
  logic [MW-1:0] mr_q, mr_r;
  logic [MW-31:0] meters;
  logic [gcd_pkg::CHORD_W-1:0] chord_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_valid_i) begin
      rad_q <= cfg_data_i;
    end
  end

  assign pipe_en         = !vld_q[LT-1] || m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;
  assign s_accept        = s_axis_tvalid_i && pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LT-2:0], s_accept};
    end
  end

  assign lon_a = s_axis_tdata_i[LW-1:0];
  assign lat_a = LW'($signed(s_axis_tdata_i[LW+AW-1:LW]));
  assign lon_b = s_axis_tdata_i[2*LW+AW-1:LW+AW];
  assign lat_b = LW'($signed(s_axis_tdata_i[2*LW+2*AW-1:2*LW+AW]));

  gcd_sincos u_lon_a (.clk_i, .en_i(pipe_en), .angle_i(lon_a), .sin_o(slon_a), .cos_o(clon_a));
  gcd_sincos u_lat_a (.clk_i, .en_i(pipe_en), .angle_i(lat_a), .sin_o(slat_a), .cos_o(clat_a));
  gcd_sincos u_lon_b (.clk_i, .en_i(pipe_en), .angle_i(lon_b), .sin_o(slon_b), .cos_o(clon_b));
  gcd_sincos u_lat_b (.clk_i, .en_i(pipe_en), .angle_i(lat_b), .sin_o(slat_b), .cos_o(clat_b));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pxa_q    <= PW'(clon_a) * PW'(clat_a);
      pza_q    <= PW'(slon_a) * PW'(clat_a);
      pxb_q    <= PW'(clon_b) * PW'(clat_b);
      pzb_q    <= PW'(slon_b) * PW'(clat_b);
      slat_a_q <= slat_a;
      slat_b_q <= slat_b;
    end
  end

  assign rxa = (pxa_q + P_RND) >>> 30;
  assign rza = (pza_q + P_RND) >>> 30;
  assign rxb = (pxb_q + P_RND) >>> 30;
  assign rzb = (pzb_q + P_RND) >>> 30;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dx_q <= DW'(rxa) - DW'(rxb);
      dy_q <= DW'(slat_a_q) - DW'(slat_b_q);
      dz_q <= DW'(rza) - DW'(rzb);
    end
  end

  assign ax = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign ay = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
  assign az = dz_q[DW-1] ? DW'(-dz_q) : DW'(dz_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sx_q  <= SW'(SW'(ax) * SW'(ax));
      sy_q  <= SW'(SW'(ay) * SW'(ay));
      sz_q  <= SW'(SW'(az) * SW'(az));
      sum_q <= sx_q + sy_q + sz_q;
    end
  end

  gcd_isqrt u_isqrt (.clk_i, .en_i(pipe_en), .v_i(sum_q), .root_o(root));

  assign mr_r   = mr_q + M_RND;
  assign meters = mr_r[MW-1:30];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mr_q    <= MW'(root) * MW'(rad_q);
      chord_q <= (meters > CHORD_MAX) ? CHORD_MAX[gcd_pkg::CHORD_W-1:0]
                                      : meters[gcd_pkg::CHORD_W-1:0];
    end
  end

  assign m_axis_tvalid_o = vld_q[LT-1];
  assign m_axis_tdata_o  = gcd_pkg::OUT_TW'(chord_q);

  `GCD_ASSERT(a_stall_holds, !pipe_en |=> $stable(vld_q))
  `GCD_ASSERT(a_accept_enters, s_accept |=> vld_q[0])
  `GCD_ASSERT(a_bubble_enters, (pipe_en && !s_accept) |=> !vld_q[0])

endmodule
